// ===== hw/rtl/sdc_pkg.sv =====
// Shared types, constants and helpers for the slab dipole correction block.
// Used by sdc_mul, sdc_div12 and slab_dipole_correction_top; no dependencies.
package sdc_pkg;

    // Fixed point layout: inputs Q(32-F).F, sums and results Q(64-2F).2F
    localparam int FRAC_BITS = 16;
    localparam int SHIFT_W   = 6;

    localparam logic [SHIFT_W-1:0] SH_NONE = SHIFT_W'(0);
    localparam logic [SHIFT_W-1:0] SH_HALF = SHIFT_W'(1);
    localparam logic [SHIFT_W-1:0] SH_F    = SHIFT_W'(FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SH_2F   = SHIFT_W'(2 * FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SH_INV  = SHIFT_W'(48);
    localparam logic [SHIFT_W-1:0] SH_PI2  = SHIFT_W'(60);
    localparam logic [SHIFT_W-1:0] SH_PI4  = SHIFT_W'(59);
    localparam logic [SHIFT_W-1:0] SH_DIV3 = SHIFT_W'(63);

    // pi in Q3.61
    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;

    // (2^63 + 1) / 3, reciprocal of three in Q1.63
    localparam logic [63:0] RECIP3_Q63 = 64'h2AAA_AAAA_AAAA_AAAB;

    // Net charge counts as nonzero above 1e-5: |Q| * 100000 > 2^F
    localparam logic [16:0] CHARGE_SCALE = 17'd100000;
    localparam logic [48:0] CHARGE_LIMIT = 49'(1) << FRAC_BITS;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // Item modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ACC   = 2'd1;
    localparam logic [1:0] MODE_CORR  = 2'd2;

    // Register indexes
    localparam logic [7:0] REG_INV_VOLUME   = 8'd0;
    localparam logic [7:0] REG_SLAB_HEIGHT  = 8'd1;
    localparam logic [7:0] REG_TOTAL_CHARGE = 8'd2;
    localparam logic [7:0] REG_COULOMB      = 8'd3;
    localparam logic [7:0] REG_ATOM_EN      = 8'd4;
    localparam logic [7:0] REG_GLOBAL_EN    = 8'd5;

    // One request to the shared multiplier
    typedef struct packed {
        logic [63:0]        a;
        logic               a_signed;
        logic [63:0]        b;
        logic               b_signed;
        logic [SHIFT_W-1:0] sh;
        logic               flip;
    } mul_req_t;

    typedef struct packed {
        logic signed [63:0] res;
        logic               clip;
    } sat_t;

    // Saturating add or subtract of two signed 64-bit values
    function automatic sat_t sat_addsub(logic signed [63:0] a, logic signed [63:0] b,
                                        logic sub);
        logic signed [64:0] s;
        sat_t o;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        o.clip = (s[64] != s[63]);
        o.res  = o.clip ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
        return o;
    endfunction

endpackage

// ===== hw/rtl/slab_dipole_correction_top.sv =====
// Slab dipole correction: sequencer, sums, registers and output stage.
// Instantiates sdc_mul and sdc_div12; depends on sdc_pkg.
//
// Usage: items enter on the s_ channel (tuser = mode, tdata = charge, z).
// Mode 0 clears the dipole and second-moment sums and the sticky flag,
// mode 1 adds one atom to the sums, mode 2 returns the atom's z force
// correction and, when enabled, its per-atom energy. Every item gives one
// result on the m_ channel with the dipole sum, the global energy
// correction, force, atom energy and the sticky saturation flag.
// One item at a time runs through a sequencer over one shared multiplier;
// the divide by twelve is a reciprocal multiply on the same unit. The result
// becomes valid in the same cycle as s_tready returns; items in mode 2 with
// both energies on take longest. s_tready is high only while idle. The
// result sits in an output register; when the receiver stalls, the block
// finishes the next item and then holds it until the register frees.
// Registers are written on the cfg_ channel, always ready; the user must
// write them only while idle, the block does not enforce it. Reset clears
// sums, flags and registers but sets Coulomb to 65536 and global energy on.
module slab_dipole_correction_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // charge[31:0], z_position[63:32]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // dipole_total[63:0], energy_correction[127:64], force_delta[191:128],
    // atom_energy_delta[255:192]
    output logic [255:0] m_tdata,
    output logic [0:0]   m_tuser,   // saturated[0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import sdc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef enum logic [4:0] {
        S_QZ, S_QZQ, S_QH, S_ACC_D, S_M, S_ACC_R, S_RSEL, S_QHH_M, S_QHH_D,
        S_E_DD, S_E_QR, S_E_SUB1, S_E_QQ, S_E_SUB2,
        S_F_SUB, S_F_M,
        S_A_U, S_A_S, S_A_H, S_A_W, S_A_SUB1, S_A_SUB2, S_A_M,
        S_C1, S_C2, S_C3, S_OUT
    } step_t;

    typedef enum logic [1:0] {
        CH_ENERGY,
        CH_FORCE,
        CH_ATOM
    } chain_t;

    // Configuration
    logic [47:0]        inv_reg;
    logic [31:0]        height_reg;
    logic signed [31:0] qtot_reg;
    logic [31:0]        coul_reg;
    logic               atom_en_reg;
    logic               glob_en_reg;

    // Sequencer and working values
    state_t             state_reg;
    step_t              step_reg;
    step_t              step_next;
    chain_t             chain_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] z_reg;
    logic signed [63:0] dip_reg;
    logic signed [63:0] sec_reg;
    logic               sticky_reg;
    logic               clip_reg;
    logic signed [63:0] qz_reg;
    logic signed [63:0] qzq_reg;
    logic signed [63:0] qh_reg;
    logic signed [63:0] r_reg;
    logic signed [63:0] qhh_reg;
    logic signed [63:0] w_reg;
    logic signed [63:0] h_reg;
    logic signed [63:0] en_reg;
    logic signed [63:0] fo_reg;
    logic signed [63:0] ae_reg;

    // Output stage
    logic               m_tvalid_reg;
    logic [255:0]       m_tdata_reg;
    logic               m_tuser_reg;

    logic               in_acc;
    logic               step_is_mul;
    logic               mul_start;
    mul_req_t           mul_req;
    mul_req_t           div_req;
    logic               mul_busy;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               mul_clip;
    logic signed [63:0] alu_a;
    logic signed [63:0] alu_b;
    logic               alu_sub;
    sat_t               alu_out;
    logic [31:0]        qtot_mag;
    logic [48:0]        qtot_scaled;
    logic               use_second;
    logic               emit_ok;
    step_t              after_energy;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign emit_ok   = !m_tvalid_reg || m_tready;

    // Second moment enters when per-atom energy is on or the net charge is nonzero
    always_comb
    begin
        qtot_mag    = qtot_reg[31] ? 32'(-qtot_reg) : qtot_reg;
        qtot_scaled = qtot_mag * CHARGE_SCALE;
        use_second  = atom_en_reg || (qtot_scaled > CHARGE_LIMIT);
    end

    // Step order
    always_comb
    begin
        after_energy = (mode_reg == MODE_CORR) ? S_F_SUB : S_OUT;
        case (step_reg)
            S_QZ:     step_next = S_QZQ;
            S_QZQ:    step_next = S_QH;
            S_QH:     step_next = (mode_reg == MODE_ACC) ? S_ACC_D : S_RSEL;
            S_ACC_D:  step_next = S_M;
            S_M:      step_next = S_ACC_R;
            S_ACC_R:  step_next = S_RSEL;
            S_RSEL:   step_next = S_QHH_M;
            S_QHH_M:  step_next = S_QHH_D;
            S_QHH_D:  step_next = glob_en_reg ? S_E_DD : after_energy;
            S_E_DD:   step_next = S_E_QR;
            S_E_QR:   step_next = S_E_SUB1;
            S_E_SUB1: step_next = S_E_QQ;
            S_E_QQ:   step_next = S_E_SUB2;
            S_E_SUB2: step_next = S_C1;
            S_F_SUB:  step_next = S_F_M;
            S_F_M:    step_next = S_C1;
            S_A_U:    step_next = S_A_S;
            S_A_S:    step_next = S_A_H;
            S_A_H:    step_next = S_A_W;
            S_A_W:    step_next = S_A_SUB1;
            S_A_SUB1: step_next = S_A_SUB2;
            S_A_SUB2: step_next = S_A_M;
            S_A_M:    step_next = S_C1;
            S_C1:     step_next = S_C2;
            S_C2:     step_next = S_C3;
            S_C3:
            begin
                case (chain_reg)
                    CH_ENERGY: step_next = after_energy;
                    CH_FORCE:  step_next = atom_en_reg ? S_A_U : S_OUT;
                    default:   step_next = S_OUT;
                endcase
            end
            default:  step_next = S_OUT;
        endcase
    end

    // Multiplier operands for each step
    always_comb
    begin
        mul_req = '{a: 64'(q_reg), a_signed: 1'b1, b: 64'(z_reg), b_signed: 1'b1,
                    sh: SH_F, flip: 1'b0};
        step_is_mul = 1'b1;
        case (step_reg)
            S_QZ:
            begin
                mul_req.sh = SH_NONE;
            end
            S_QZQ:
            begin
                mul_req.a  = 64'(qtot_reg);
                mul_req.sh = SH_NONE;
            end
            S_QH:
            begin
                mul_req.a        = 64'(qtot_reg);
                mul_req.b        = {32'd0, height_reg};
                mul_req.b_signed = 1'b0;
                mul_req.sh       = SH_NONE;
            end
            S_M:     mul_req.a = qz_reg;
            S_QHH_M:
            begin
                mul_req.a        = qh_reg;
                mul_req.b        = {32'd0, height_reg};
                mul_req.b_signed = 1'b0;
            end
            S_QHH_D: mul_req = div_req;
            S_E_DD:
            begin
                mul_req.a  = dip_reg;
                mul_req.b  = dip_reg;
                mul_req.sh = SH_2F;
            end
            S_E_QR:
            begin
                mul_req.a = 64'(qtot_reg);
                mul_req.b = r_reg;
            end
            S_E_QQ:
            begin
                mul_req.a = 64'(qtot_reg);
                mul_req.b = qhh_reg;
            end
            S_F_M:   mul_req.b = w_reg;
            S_A_U:   mul_req.a = qzq_reg;
            S_A_H:
            begin
                mul_req.a        = w_reg;
                mul_req.b        = 64'd1;
                mul_req.b_signed = 1'b0;
                mul_req.sh       = SH_HALF;
            end
            S_A_W:
            begin
                mul_req.a = 64'(z_reg);
                mul_req.b = dip_reg;
            end
            S_A_M:   mul_req.b = w_reg;
            S_C1:
            begin
                mul_req.a        = w_reg;
                mul_req.b        = {16'd0, inv_reg};
                mul_req.b_signed = 1'b0;
                mul_req.sh       = SH_INV;
            end
            S_C2:
            begin
                mul_req.a        = w_reg;
                mul_req.b        = {32'd0, coul_reg};
                mul_req.b_signed = 1'b0;
            end
            S_C3:
            begin
                mul_req.a        = w_reg;
                mul_req.b        = PI_Q61;
                mul_req.b_signed = 1'b0;
                mul_req.sh       = (chain_reg == CH_FORCE) ? SH_PI4 : SH_PI2;
                mul_req.flip     = (chain_reg == CH_FORCE);
            end
            default: step_is_mul = 1'b0;
        endcase
    end

    // Saturating adder operands
    always_comb
    begin
        alu_a   = w_reg;
        alu_b   = h_reg;
        alu_sub = 1'b1;
        case (step_reg)
            S_ACC_D:
            begin
                alu_a   = dip_reg;
                alu_b   = qz_reg;
                alu_sub = 1'b0;
            end
            S_ACC_R:
            begin
                alu_a   = sec_reg;
                alu_sub = 1'b0;
            end
            S_F_SUB:
            begin
                alu_a = dip_reg;
                alu_b = qzq_reg;
            end
            S_A_S:
            begin
                alu_a   = r_reg;
                alu_b   = w_reg;
                alu_sub = 1'b0;
            end
            S_A_SUB2: alu_b = qhh_reg;
            default:  alu_b = h_reg;
        endcase
        alu_out = sat_addsub(alu_a, alu_b, alu_sub);
    end

    assign mul_start = (state_reg == ST_EXEC) && step_is_mul;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg     <= 48'd0;
            height_reg  <= 32'd0;
            qtot_reg    <= 32'sd0;
            coul_reg    <= 32'd65536;
            atom_en_reg <= 1'b0;
            glob_en_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INV_VOLUME:   inv_reg     <= cfg_data[47:0];
                REG_SLAB_HEIGHT:  height_reg  <= cfg_data[31:0];
                REG_TOTAL_CHARGE: qtot_reg    <= cfg_data[31:0];
                REG_COULOMB:      coul_reg    <= cfg_data[31:0];
                REG_ATOM_EN:      atom_en_reg <= cfg_data[0];
                REG_GLOBAL_EN:    glob_en_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Sequencer, sums and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= S_QZ;
            chain_reg    <= CH_ENERGY;
            dip_reg      <= 64'sd0;
            sec_reg      <= 64'sd0;
            sticky_reg   <= 1'b0;
            clip_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !(state_reg == ST_EMIT && emit_ok))
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        mode_reg  <= s_tuser;
                        q_reg     <= s_tdata[31:0];
                        z_reg     <= s_tdata[63:32];
                        en_reg    <= 64'sd0;
                        fo_reg    <= 64'sd0;
                        ae_reg    <= 64'sd0;
                        clip_reg  <= 1'b0;
                        step_reg  <= S_QZ;
                        state_reg <= ST_EXEC;
                        if (s_tuser == MODE_CLEAR)
                        begin
                            dip_reg    <= 64'sd0;
                            sec_reg    <= 64'sd0;
                            sticky_reg <= 1'b0;
                        end
                    end
                end
                ST_EXEC:
                begin
                    if (step_reg == S_OUT)
                        state_reg <= ST_EMIT;
                    else if (step_is_mul)
                        state_reg <= ST_MUL;
                    else
                    begin
                        // Adder steps finish here
                        case (step_reg)
                            S_ACC_D: dip_reg <= alu_out.res;
                            S_ACC_R: sec_reg <= alu_out.res;
                            default: w_reg   <= alu_out.res;
                        endcase
                        if (step_reg == S_RSEL)
                            r_reg <= use_second ? sec_reg : 64'sd0;
                        else
                            clip_reg <= clip_reg | alu_out.clip;
                        if (step_reg == S_E_SUB2)
                            chain_reg <= CH_ENERGY;
                        step_reg <= step_next;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        case (step_reg)
                            S_QZ:    qz_reg  <= mul_res;
                            S_QZQ:   qzq_reg <= mul_res;
                            S_QH:    qh_reg  <= mul_res;
                            S_QHH_D: qhh_reg <= mul_res;
                            S_M, S_E_QR, S_E_QQ, S_A_H: h_reg <= mul_res;
                            S_C3:
                            begin
                                case (chain_reg)
                                    CH_ENERGY: en_reg <= mul_res;
                                    CH_FORCE:  fo_reg <= mul_res;
                                    default:   ae_reg <= mul_res;
                                endcase
                            end
                            default: w_reg <= mul_res;
                        endcase
                        if (step_reg == S_F_M)
                            chain_reg <= CH_FORCE;
                        else if (step_reg == S_A_M)
                            chain_reg <= CH_ATOM;
                        clip_reg  <= clip_reg | mul_clip;
                        step_reg  <= step_next;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EMIT:
                begin
                    // Hold the finished item until the output register frees
                    if (emit_ok)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {ae_reg, fo_reg, en_reg, dip_reg};
                        m_tuser_reg  <= sticky_reg | clip_reg;
                        sticky_reg   <= sticky_reg | clip_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    sdc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .req   (mul_req),
        .busy  (mul_busy),
        .done  (mul_done),
        .res   (mul_res),
        .clip  (mul_clip)
    );

    sdc_div12 u_div (
        .x   (w_reg),
        .req (div_req)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // The multiplier is never started while it is still working
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // A result completes only while the sequencer waits for it
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier result with no waiting step");

    // The sticky flag drops only after a clear item
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sticky_reg) |-> $past(in_acc && s_tuser == MODE_CLEAR))
        else $error("sticky saturation cleared without a clear item");

    // A clear item leaves the dipole sum at zero
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == MODE_CLEAR) |=> (dip_reg == 64'sd0))
        else $error("dipole sum not cleared");

endmodule

// ===== hw/rtl/sdc_mul.sv =====
// Iterative 64x64 multiplier with round-half-away, right shift and saturation.
// Four 32x32 partial products, then round and shift; depends on sdc_pkg.
module sdc_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sdc_pkg::mul_req_t    req,
    output logic                 busy,
    output logic                 done,
    output logic signed [63:0]   res,
    output logic                 clip
);
    import sdc_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_PROD = 4'b0010,
        M_RND  = 4'b0100,
        M_SHF  = 4'b1000
    } mstate_t;

    mstate_t            state_reg;
    logic [63:0]        a_reg;
    logic [63:0]        b_reg;
    logic [SHIFT_W-1:0] sh_reg;
    logic               neg_reg;
    logic [1:0]         cnt_reg;
    logic [127:0]       acc_reg;
    logic               done_reg;
    logic signed [63:0] res_reg;
    logic               clip_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  part;
    logic [127:0] addend;
    logic [127:0] half;
    logic [127:0] shifted;
    logic [63:0]  limit;
    logic         over;
    logic         a_neg;
    logic         b_neg;

    // Select one partial product and place it
    always_comb
    begin
        a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        part   = a_half * b_half;
        case (cnt_reg)
            2'd0:    addend = {64'd0, part};
            2'd3:    addend = {part, 64'd0};
            default: addend = {32'd0, part, 32'd0};
        endcase
        half    = (sh_reg == SH_NONE) ? 128'd0 : (128'd1 << (sh_reg - SHIFT_W'(1)));
        shifted = acc_reg >> sh_reg;
        limit   = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        over    = (shifted[127:64] != 64'd0) || (shifted[63:0] > limit);
        a_neg   = req.a_signed & req.a[63];
        b_neg   = req.b_signed & req.b[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= M_PROD;
                        cnt_reg   <= 2'd0;
                        acc_reg   <= 128'd0;
                    end
                end
                M_PROD:
                begin
                    acc_reg <= acc_reg + addend;
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                        state_reg <= M_RND;
                end
                M_RND:
                begin
                    acc_reg   <= acc_reg + half;
                    state_reg <= M_SHF;
                end
                M_SHF:
                begin
                    clip_reg  <= over;
                    res_reg   <= neg_reg ? -(over ? limit : shifted[63:0])
                                         : (over ? limit : shifted[63:0]);
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    // Capture operand magnitudes and the result sign on start
    always_ff @(posedge clk)
    begin
        if (start && state_reg == M_IDLE)
        begin
            a_reg   <= a_neg ? -req.a : req.a;
            b_reg   <= b_neg ? -req.b : req.b;
            sh_reg  <= req.sh;
            neg_reg <= a_neg ^ b_neg ^ req.flip;
        end
    end

    assign busy = (state_reg != M_IDLE);
    assign done = done_reg;
    assign res  = res_reg;
    assign clip = clip_reg;

endmodule

// ===== hw/rtl/sdc_div12.sv =====
// Signed divide by twelve, truncating toward zero, as one reciprocal multiply.
// Builds the request for the shared sdc_mul; depends on sdc_pkg.
module sdc_div12 (
    input  logic signed [63:0] x,
    output sdc_pkg::mul_req_t  req
);
    import sdc_pkg::*;

    logic [63:0] x_mag;
    logic [63:0] quarter;

    // |x| / 12 is floor(n / 3) with n = |x| / 4; rounding (n - 1) / 3 to the
    // nearest lands on floor(n / 3), and the sign of x goes back on as a flip
    always_comb
    begin
        x_mag   = x[63] ? (64'd0 - x) : x;
        quarter = x_mag >> 2;
        req     = '{a: quarter - 64'd1, a_signed: 1'b1, b: RECIP3_Q63, b_signed: 1'b0,
                    sh: SH_DIV3, flip: x[63]};
    end

endmodule
